/* sv/sclt_pkg.sv */
package sclt_pkg;

  localparam int MAX_PARAMS    = 4;
  localparam int MAX_LINE      = 256;
  localparam int POS_W         = $clog2(MAX_LINE);
  localparam int PCNT_W        = 3;
  localparam int PIDX_W        = 2;
  localparam int CALL_MAX_ARGS = 4;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_PARAM  = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    CMD_CALL  = 3'd0,
    CMD_GET   = 3'd1,
    CMD_SET   = 3'd2,
    CMD_READ  = 3'd3,
    CMD_WRITE = 3'd4,
    CMD_LF    = 3'd5,
    CMD_LV    = 3'd6
  } cmd_e;

  typedef enum logic [2:0] {
    RSN_NONE        = 3'd0,
    RSN_ILLEGAL     = 3'd1,
    RSN_EMPTY_NAME  = 3'd2,
    RSN_EMPTY_PARAM = 3'd3,
    RSN_TOO_MANY    = 3'd4,
    RSN_WRONG_COUNT = 3'd5,
    RSN_STRING      = 3'd6,
    RSN_TOO_LONG    = 3'd7
  } reason_e;

  // Second (or only) result of a character's transaction group
  typedef enum logic [1:0] {
    TAIL_NONE   = 2'd0,
    TAIL_FINISH = 2'd1,
    TAIL_REJECT = 2'd2
  } tail_e;

  // One queued character's worth of results
  typedef struct packed {
    logic              has_param;
    tail_e             tail;
    reason_e           reason;
    logic [PIDX_W-1:0] pidx;
    logic [POS_W-1:0]  pstart;
    logic [POS_W-1:0]  pend;
    logic              pstr;
    cmd_e              ctype;
    logic [PCNT_W-1:0] pcount;
    logic              mark0;
    logic              mark1;
    logic [POS_W-1:0]  name_end;
  } entry_t;

endpackage

/* sv/shell_command_line_tokenizer.sv */
// The first result of a character is registered in the queue and offered from its head.
// Throughput: one character per cycle while in_stall_o is low; a character with two
// results holds the output for both, and a four-entry queue between decoder and
// formatter absorbs it. in_stall_o rises only while that queue is full.
// Reset (rst_ni, asynchronous, active low) idles the tokenizer and empties the queue;
// stored name characters are not cleared.
module shell_command_line_tokenizer
  import sclt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        ch_i,
  input  logic              first_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        kind_o,
  output logic              is_last_o,
  output logic [PIDX_W-1:0] param_index_o,
  output logic [POS_W-1:0]  param_start_o,
  output logic [POS_W-1:0]  param_end_o,
  output logic              param_is_string_o,
  output logic [2:0]        command_type_o,
  output logic [PCNT_W-1:0] param_count_o,
  output logic [POS_W-1:0]  name_end_o,
  output logic [2:0]        reject_reason_o
);

  logic   accept;
  logic   push;
  logic   pop;
  logic   full;
  logic   empty;
  entry_t entry;
  entry_t head;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  sclt_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .ch_i     (ch_i),
    .first_i  (first_i),
    .push_o   (push),
    .entry_o  (entry)
  );

  sclt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  sclt_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .empty_i           (empty),
    .head_i            (head),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .kind_o            (kind_o),
    .is_last_o         (is_last_o),
    .param_index_o     (param_index_o),
    .param_start_o     (param_start_o),
    .param_end_o       (param_end_o),
    .param_is_string_o (param_is_string_o),
    .command_type_o    (command_type_o),
    .param_count_o     (param_count_o),
    .name_end_o        (name_end_o),
    .reject_reason_o   (reject_reason_o)
  );

endmodule

/* sv/sclt_front.sv */
module sclt_front
  import sclt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] ch_i,
  input  logic       first_i,
  output logic       push_o,
  output entry_t     entry_o
);

  localparam logic [7:0] CH_MIN    = 8'd33;
  localparam logic [7:0] CH_MAX    = 8'd126;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam int         NAME_KEEP = 5;
  localparam logic [2:0] NAME_SAT  = 3'd6;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_NAME   = 2'd1,
    PH_PARAMS = 2'd2
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic [2:0]            name_len_q, name_len_d;
  logic [POS_W-1:0]      pbeg_q, pbeg_d;
  logic [PCNT_W-1:0]     ptot_q, ptot_d;
  logic [MAX_PARAMS-1:0] marks_q, marks_d;
  logic [7:0]            prev_q;
  logic [POS_W-1:0]      name_last_q, name_last_d;
  logic [7:0]            name_q [NAME_KEEP];

  // Values seen by this character, after a new command start
  phase_e                phase_c;
  logic [POS_W-1:0]      pos_c;
  logic [2:0]            name_len_c;
  logic [PCNT_W-1:0]     ptot_c;
  logic [MAX_PARAMS-1:0] marks_c;
  logic [7:0]            prev_c;
  logic                  active;
  logic                  name_we;
  logic                  quoted;
  cmd_e                  ctype;
  entry_t                ent;

  assign active     = first_i || (phase_q != PH_IDLE);
  assign phase_c    = first_i ? PH_NAME : phase_q;
  assign pos_c      = first_i ? '0 : pos_q;
  assign name_len_c = first_i ? '0 : name_len_q;
  assign ptot_c     = first_i ? '0 : ptot_q;
  assign marks_c    = first_i ? '0 : marks_q;
  assign prev_c     = first_i ? '0 : prev_q;
  assign quoted     = (prev_c == CH_QUOTE);

  // Classify the stored call name
  always_comb begin
    ctype = CMD_CALL;
    if (name_len_q == 3'd2 && name_q[0] == "l" && name_q[1] == "f") begin
      ctype = CMD_LF;
    end else if (name_len_q == 3'd2 && name_q[0] == "l" && name_q[1] == "v") begin
      ctype = CMD_LV;
    end else if (name_len_q == 3'd3 && name_q[0] == "g" && name_q[1] == "e"
                 && name_q[2] == "t") begin
      ctype = CMD_GET;
    end else if (name_len_q == 3'd3 && name_q[0] == "s" && name_q[1] == "e"
                 && name_q[2] == "t") begin
      ctype = CMD_SET;
    end else if (name_len_q == 3'd4 && name_q[0] == "r" && name_q[1] == "e"
                 && name_q[2] == "a" && name_q[3] == "d") begin
      ctype = CMD_READ;
    end else if (name_len_q == 3'd5 && name_q[0] == "w" && name_q[1] == "r"
                 && name_q[2] == "i" && name_q[3] == "t" && name_q[4] == "e") begin
      ctype = CMD_WRITE;
    end
  end

  // Decode one character and compute next state
  always_comb begin
    ent          = '0;
    ent.tail     = TAIL_NONE;
    ent.reason   = RSN_NONE;
    ent.ctype    = ctype;
    ent.name_end = name_last_q;
    phase_d      = phase_c;
    pos_d        = pos_c;
    name_len_d   = name_len_c;
    pbeg_d       = pbeg_q;
    ptot_d       = ptot_c;
    marks_d      = marks_c;
    name_last_d  = name_last_q;
    name_we      = 1'b0;

    if (ch_i < CH_MIN || ch_i > CH_MAX) begin
      ent.tail   = TAIL_REJECT;
      ent.reason = RSN_ILLEGAL;
    end else if (phase_c == PH_NAME) begin
      if (ch_i == CH_LPAREN) begin
        if (pos_c == '0) begin
          ent.tail   = TAIL_REJECT;
          ent.reason = RSN_EMPTY_NAME;
        end else begin
          name_last_d = pos_c - POS_W'(1);
          pbeg_d      = pos_c + POS_W'(1);
          phase_d     = PH_PARAMS;
        end
      end else begin
        name_we = (name_len_c < 3'(NAME_KEEP));
        if (name_len_c < NAME_SAT) name_len_d = name_len_c + 3'd1;
      end
    end else if (ch_i == CH_COMMA || ch_i == CH_RPAREN) begin
      priority if (ch_i == CH_RPAREN && ptot_c == '0 && pos_c == pbeg_q) begin
        ent.tail = TAIL_FINISH;
      end else if (pos_c == pbeg_q) begin
        ent.tail   = TAIL_REJECT;
        ent.reason = RSN_EMPTY_PARAM;
      end else if (ptot_c >= PCNT_W'(MAX_PARAMS)) begin
        ent.tail   = TAIL_REJECT;
        ent.reason = RSN_TOO_MANY;
      end else begin
        ent.has_param = 1'b1;
        ent.pidx      = ptot_c[PIDX_W-1:0];
        ent.pstart    = quoted ? pbeg_q + POS_W'(1) : pbeg_q;
        ent.pend      = quoted ? pos_c - POS_W'(2) : pos_c - POS_W'(1);
        ent.pstr      = quoted;
        if (quoted) marks_d[ptot_c[PIDX_W-1:0]] = 1'b1;
        ptot_d = ptot_c + PCNT_W'(1);
        if (ch_i == CH_COMMA) begin
          pbeg_d = pos_c + POS_W'(1);
        end else begin
          ent.tail = TAIL_FINISH;
        end
      end
    end

    ent.pcount = ptot_d;
    ent.mark0  = marks_d[0];
    ent.mark1  = marks_d[1];

    // End of line without a closing parenthesis
    if (ent.tail == TAIL_NONE) begin
      if (pos_c >= POS_W'(MAX_LINE - 1)) begin
        ent.tail   = TAIL_REJECT;
        ent.reason = RSN_TOO_LONG;
      end else begin
        pos_d = pos_c + POS_W'(1);
      end
    end
    if (ent.tail != TAIL_NONE) phase_d = PH_IDLE;
  end

  assign push_o  = accept_i && active && (ent.has_param || ent.tail != TAIL_NONE);
  assign entry_o = ent;

  // Hold control state; advance on each accepted character of a live command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      pos_q       <= '0;
      name_len_q  <= '0;
      pbeg_q      <= '0;
      ptot_q      <= '0;
      marks_q     <= '0;
      prev_q      <= '0;
      name_last_q <= '0;
    end else if (accept_i && active) begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      name_len_q  <= name_len_d;
      pbeg_q      <= pbeg_d;
      ptot_q      <= ptot_d;
      marks_q     <= marks_d;
      prev_q      <= ch_i;
      name_last_q <= name_last_d;
    end
  end

  // Keep the first name characters
  always_ff @(posedge clk_i) begin
    if (accept_i && name_we) begin
      name_q[name_len_c] <= ch_i;
    end
  end

  a_param_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptot_q <= PCNT_W'(MAX_PARAMS))
    else $error("parameter count above limit");

endmodule

/* sv/sclt_fifo.sv */
module sclt_fifo
  import sclt_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  input  logic   pop_i,
  output logic   full_o,
  output logic   empty_o,
  output entry_t head_o
);

  entry_t                mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q;
  logic [FIFO_PTR_W-1:0] rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + FIFO_CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - FIFO_CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= entry_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !(push_i && !pop_i))
    else $error("queue overflow");

endmodule

/* sv/sclt_back.sv */
module sclt_back
  import sclt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  entry_t            head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        kind_o,
  output logic              is_last_o,
  output logic [PIDX_W-1:0] param_index_o,
  output logic [POS_W-1:0]  param_start_o,
  output logic [POS_W-1:0]  param_end_o,
  output logic              param_is_string_o,
  output logic [2:0]        command_type_o,
  output logic [PCNT_W-1:0] param_count_o,
  output logic [POS_W-1:0]  name_end_o,
  output logic [2:0]        reject_reason_o
);

  logic    beat_q;
  logic    show_param;
  logic    xfer;
  reason_e chk_reason;

  // Apply the command type's count and string checks
  always_comb begin
    chk_reason = RSN_NONE;
    unique case (head_i.ctype)
      CMD_CALL: begin
        if (head_i.pcount > PCNT_W'(CALL_MAX_ARGS)) chk_reason = RSN_TOO_MANY;
      end
      CMD_GET, CMD_READ: begin
        if (head_i.pcount != PCNT_W'(1)) chk_reason = RSN_WRONG_COUNT;
        else if (head_i.mark0)           chk_reason = RSN_STRING;
      end
      CMD_SET: begin
        if (head_i.pcount != PCNT_W'(2)) chk_reason = RSN_WRONG_COUNT;
        else if (head_i.mark1)           chk_reason = RSN_STRING;
      end
      CMD_WRITE: begin
        if (head_i.pcount != PCNT_W'(2))       chk_reason = RSN_WRONG_COUNT;
        else if (head_i.mark0 || head_i.mark1) chk_reason = RSN_STRING;
      end
      default: chk_reason = RSN_NONE;
    endcase
  end

  assign show_param = head_i.has_param && !beat_q;

  // Format the current result transaction
  always_comb begin
    kind_o            = KIND_PARAM;
    is_last_o         = 1'b1;
    param_index_o     = '0;
    param_start_o     = '0;
    param_end_o       = '0;
    param_is_string_o = 1'b0;
    command_type_o    = CMD_CALL;
    param_count_o     = '0;
    name_end_o        = '0;
    reject_reason_o   = RSN_NONE;
    if (show_param) begin
      is_last_o         = (head_i.tail == TAIL_NONE);
      param_index_o     = head_i.pidx;
      param_start_o     = head_i.pstart;
      param_end_o       = head_i.pend;
      param_is_string_o = head_i.pstr;
    end else if (head_i.tail == TAIL_FINISH) begin
      kind_o          = (chk_reason == RSN_NONE) ? KIND_ACCEPT : KIND_REJECT;
      command_type_o  = head_i.ctype;
      param_count_o   = head_i.pcount;
      name_end_o      = head_i.name_end;
      reject_reason_o = chk_reason;
    end else begin
      kind_o          = KIND_REJECT;
      reject_reason_o = head_i.reason;
    end
  end

  assign out_valid_o = !empty_i;
  assign xfer        = out_valid_o && !out_stall_i;
  assign pop_o       = xfer && is_last_o;

  // Step through the results of the head entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= 1'b0;
    end else if (xfer) begin
      beat_q <= !is_last_o;
    end
  end

  a_second_beat_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && !is_last_o) |=> (out_valid_o && beat_q))
    else $error("second result of a character lost");

  a_beat_has_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_q |-> (out_valid_o && head_i.has_param && head_i.tail != TAIL_NONE))
    else $error("second beat on a single-result entry");

  a_reason_matches_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((kind_o == KIND_REJECT) == (reject_reason_o != RSN_NONE)))
    else $error("reject reason disagrees with result kind");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb
  import sclt_pkg::*;
();

  localparam int RANDOM_TARGET = 1900;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int QUIET_FROM    = 800;
  localparam int QUIET_TO      = 1400;
  localparam int TAIL_CYCLES   = 16;
  localparam int LONG_FORMS    = 4;

  localparam logic [7:0] CH_OPEN  = "(";
  localparam logic [7:0] CH_CLOSE = ")";
  localparam logic [7:0] CH_COMMA = ",";
  localparam logic [7:0] CH_QUOTE = "\"";

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_NAME   = 2'd1,
    PH_PARAMS = 2'd2
  } phase_e;

  typedef struct packed {
    kind_e             kind;
    logic              is_last;
    logic [PIDX_W-1:0] pidx;
    logic [POS_W-1:0]  pstart;
    logic [POS_W-1:0]  pend;
    logic              pstr;
    cmd_e              ctype;
    logic [PCNT_W-1:0] pcount;
    logic [POS_W-1:0]  name_end;
    reason_e           reason;
  } token_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       first;
  } char_item_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [7:0]        ch_i = 8'd0;
  logic              first_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [1:0]        kind_o;
  logic              is_last_o;
  logic [PIDX_W-1:0] param_index_o;
  logic [POS_W-1:0]  param_start_o;
  logic [POS_W-1:0]  param_end_o;
  logic              param_is_string_o;
  logic [2:0]        command_type_o;
  logic [PCNT_W-1:0] param_count_o;
  logic [POS_W-1:0]  name_end_o;
  logic [2:0]        reject_reason_o;

  shell_command_line_tokenizer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .ch_i             (ch_i),
    .first_i          (first_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .is_last_o        (is_last_o),
    .param_index_o    (param_index_o),
    .param_start_o    (param_start_o),
    .param_end_o      (param_end_o),
    .param_is_string_o(param_is_string_o),
    .command_type_o   (command_type_o),
    .param_count_o    (param_count_o),
    .name_end_o       (name_end_o),
    .reject_reason_o  (reject_reason_o)
  );

  // Stimulus and scoreboard storage
  char_item_t pending_chars[$];
  token_t     expected_tokens[$];
  logic [7:0] line_buf[$];
  string      cmd_names[11] = '{"lf", "lv", "get", "set", "read", "write",
                                "ge", "sets", "writes", "f", "reader"};

  int cycle_count    = 0;
  int queued_chars   = 0;
  int chars_sent     = 0;
  int mismatch_count = 0;
  int params_seen    = 0;
  int accepts_seen   = 0;
  int rejects_seen   = 0;
  int reason_hits[8] = '{default: 0};

  // Tokenizer state mirrored by the predictor
  phase_e     tk_phase    = PH_IDLE;
  logic [7:0] tk_pos      = 8'd0;
  logic [7:0] tk_name[5]  = '{default: 8'd0};
  int         tk_name_len = 0;
  logic [7:0] tk_pbegin   = 8'd0;
  logic [2:0] tk_ptotal   = 3'd0;
  logic [3:0] tk_quoted   = 4'd0;
  logic [7:0] tk_prev     = 8'd0;
  logic [7:0] tk_name_end = 8'd0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Random idle decision shared by both sides; no idling inside the quiet window
  function automatic bit idle_roll();
    if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) return 1'b0;
    return $urandom_range(99) < 19;
  endfunction

  function automatic bit name_matches(string s);
    if (tk_name_len != s.len()) return 1'b0;
    for (int i = 0; i < s.len(); i++)
      if (tk_name[i] != s[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic token_t rejection(reason_e why);
    token_t t;
    t = '0;
    t.kind   = KIND_REJECT;
    t.reason = why;
    tk_phase = PH_IDLE;
    return t;
  endfunction

  // Classify the name at ')' and apply the per-command parameter rules
  function automatic token_t close_command();
    token_t t;
    t = '0;
    t.ctype = CMD_CALL;
    if (name_matches("lf")) t.ctype = CMD_LF;
    else if (name_matches("lv")) t.ctype = CMD_LV;
    else if (name_matches("get")) t.ctype = CMD_GET;
    else if (name_matches("set")) t.ctype = CMD_SET;
    else if (name_matches("read")) t.ctype = CMD_READ;
    else if (name_matches("write")) t.ctype = CMD_WRITE;
    t.pcount   = tk_ptotal;
    t.name_end = tk_name_end;
    t.reason   = RSN_NONE;
    case (t.ctype)
      CMD_CALL: if (tk_ptotal > CALL_MAX_ARGS) t.reason = RSN_TOO_MANY;
      CMD_GET, CMD_READ: begin
        if (tk_ptotal != 3'd1) t.reason = RSN_WRONG_COUNT;
        else if (tk_quoted[0]) t.reason = RSN_STRING;
      end
      CMD_SET: begin
        if (tk_ptotal != 3'd2) t.reason = RSN_WRONG_COUNT;
        else if (tk_quoted[1]) t.reason = RSN_STRING;
      end
      CMD_WRITE: begin
        if (tk_ptotal != 3'd2) t.reason = RSN_WRONG_COUNT;
        else if (tk_quoted[0] || tk_quoted[1]) t.reason = RSN_STRING;
      end
      default: ;
    endcase
    t.kind   = (t.reason != RSN_NONE) ? KIND_REJECT : KIND_ACCEPT;
    tk_phase = PH_IDLE;
    return t;
  endfunction

  // Advance the mirrored tokenizer by one character and queue its results
  function automatic void tokenize_char(logic [7:0] c, logic first);
    token_t     res[$];
    token_t     t;
    logic [7:0] p;
    logic       q;
    if (first) begin
      tk_phase    = PH_NAME;
      tk_pos      = 8'd0;
      tk_name_len = 0;
      tk_ptotal   = 3'd0;
      tk_quoted   = 4'd0;
      tk_prev     = 8'd0;
    end else if (tk_phase == PH_IDLE) begin
      return;
    end
    p = tk_pos;

    if (c < 8'd33 || c > 8'd126) begin
      res.push_back(rejection(RSN_ILLEGAL));
    end else if (tk_phase == PH_NAME) begin
      if (c == CH_OPEN) begin
        if (p == 8'd0) begin
          res.push_back(rejection(RSN_EMPTY_NAME));
        end else begin
          tk_name_end = p - 8'd1;
          tk_pbegin   = p + 8'd1;
          tk_phase    = PH_PARAMS;
        end
      end else begin
        if (tk_name_len < 5) tk_name[tk_name_len] = c;
        if (tk_name_len < 6) tk_name_len++;
      end
    end else if (c == CH_COMMA || c == CH_CLOSE) begin
      if (c == CH_CLOSE && tk_ptotal == 3'd0 && p == tk_pbegin) begin
        res.push_back(close_command());
      end else if (p == tk_pbegin) begin
        res.push_back(rejection(RSN_EMPTY_PARAM));
      end else if (tk_ptotal >= MAX_PARAMS) begin
        res.push_back(rejection(RSN_TOO_MANY));
      end else begin
        // Only the character before the delimiter decides quoting
        q = (tk_prev == CH_QUOTE);
        t = '0;
        t.kind   = KIND_PARAM;
        t.pidx   = tk_ptotal[PIDX_W-1:0];
        t.pstart = q ? tk_pbegin + 8'd1 : tk_pbegin;
        t.pend   = q ? p - 8'd2 : p - 8'd1;
        t.pstr   = q;
        t.ctype  = CMD_CALL;
        t.reason = RSN_NONE;
        res.push_back(t);
        if (q) tk_quoted[tk_ptotal[1:0]] = 1'b1;
        tk_ptotal++;
        if (c == CH_COMMA) tk_pbegin = p + 8'd1;
        else res.push_back(close_command());
      end
    end

    tk_prev = c;
    // An unfinished command at the last line position is cut off
    if (tk_phase != PH_IDLE) begin
      if (p >= MAX_LINE - 1) res.push_back(rejection(RSN_TOO_LONG));
      else tk_pos = p + 8'd1;
    end
    if (res.size() > 0) res[res.size() - 1].is_last = 1'b1;
    foreach (res[i]) expected_tokens.push_back(res[i]);
  endfunction

  function automatic string token_str(token_t t);
    return $sformatf({"kind=%0d last=%0d idx=%0d start=%0d end=%0d str=%0d ",
                      "type=%0d cnt=%0d nend=%0d rsn=%0d"},
                     t.kind, t.is_last, t.pidx, t.pstart, t.pend, t.pstr, t.ctype,
                     t.pcount, t.name_end, t.reason);
  endfunction

  // Stimulus building helpers
  function automatic logic [7:0] pick_legal(bit in_params);
    logic [7:0] c;
    do c = 8'($urandom_range(126, 33));
    while (in_params ? (c == CH_COMMA || c == CH_CLOSE || c == CH_QUOTE)
                     : (c == CH_OPEN));
    return c;
  endfunction

  function automatic logic [7:0] pick_illegal();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c >= 8'd33 && c <= 8'd126);
    return c;
  endfunction

  function automatic void append_str(string s);
    foreach (s[i]) line_buf.push_back(s[i]);
  endfunction

  function automatic void emit_line();
    foreach (line_buf[i]) pending_chars.push_back('{ch: line_buf[i], first: (i == 0)});
    queued_chars += line_buf.size();
    line_buf.delete();
  endfunction

  function automatic void send_text(string s);
    append_str(s);
    emit_line();
  endfunction

  // Well-formed command with random name and parameters
  function automatic void build_command();
    int nparams;
    int plen;
    int style;
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(7, 1)) line_buf.push_back(pick_legal(1'b0));
    end else begin
      append_str(cmd_names[$urandom_range(10)]);
    end
    line_buf.push_back(CH_OPEN);
    nparams = ($urandom_range(9) < 7) ? $urandom_range(2) : $urandom_range(6, 3);
    for (int i = 0; i < nparams; i++) begin
      if (i != 0) line_buf.push_back(CH_COMMA);
      // quoted, closing quote only, or plain
      style = $urandom_range(5);
      if (style < 2) line_buf.push_back(CH_QUOTE);
      plen = (style < 2) ? $urandom_range(3) : $urandom_range(4, 1);
      repeat (plen) line_buf.push_back(pick_legal(1'b1));
      if (style < 3) line_buf.push_back(CH_QUOTE);
    end
    line_buf.push_back(CH_CLOSE);
  endfunction

  // Full-length line; the form decides what lands on the last position
  function automatic void build_long(int form);
    int comma_a;
    int comma_b;
    if (form == 2) begin
      repeat (MAX_LINE + 3) line_buf.push_back(pick_legal(1'b0));
    end else begin
      comma_a = $urandom_range(120, 10);
      comma_b = $urandom_range(250, 130);
      append_str("f(");
      for (int i = 2; i < MAX_LINE - 1; i++)
        line_buf.push_back((i == comma_a || i == comma_b) ? CH_COMMA : pick_legal(1'b1));
      case (form)
        0:       line_buf.push_back(CH_CLOSE);
        1:       line_buf.push_back(CH_COMMA);
        default: line_buf.push_back(pick_illegal());
      endcase
    end
  endfunction

  // Cycle count and watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_tokens.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Character driver: predict on each accepted transaction, then offer the next one
  always @(posedge clk_i or negedge rst_ni) begin : drive_chars
    char_item_t nxt;
    logic       take;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      ch_i       <= 8'd0;
      first_i    <= 1'b0;
    end else begin
      take = in_valid_i && !in_stall_o;
      if (take) begin
        tokenize_char(ch_i, first_i);
        chars_sent++;
      end
      if (!in_valid_i || take) begin
        if (pending_chars.size() != 0 && !idle_roll()) begin
          nxt = pending_chars.pop_front();
          in_valid_i <= 1'b1;
          ch_i       <= nxt.ch;
          first_i    <= nxt.first;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each transaction with the oldest expected token
  always @(posedge clk_i or negedge rst_ni) begin : watch_results
    token_t act;
    token_t exp_tok;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        act.kind     = kind_e'(kind_o);
        act.is_last  = is_last_o;
        act.pidx     = param_index_o;
        act.pstart   = param_start_o;
        act.pend     = param_end_o;
        act.pstr     = param_is_string_o;
        act.ctype    = cmd_e'(command_type_o);
        act.pcount   = param_count_o;
        act.name_end = name_end_o;
        act.reason   = reason_e'(reject_reason_o);
        if (expected_tokens.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result at cycle %0d: %s", cycle_count, token_str(act));
        end else begin
          exp_tok = expected_tokens.pop_front();
          if (act !== exp_tok) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("result mismatch at cycle %0d", cycle_count);
              $display("  expected %s", token_str(exp_tok));
              $display("  actual   %s", token_str(act));
            end
          end
          case (exp_tok.kind)
            KIND_PARAM:  params_seen++;
            KIND_ACCEPT: accepts_seen++;
            default: begin
              rejects_seen++;
              reason_hits[exp_tok.reason]++;
            end
          endcase
        end
      end
      out_stall_i <= idle_roll();
    end
  end

  // Build stimulus, release reset, then drain
  initial begin : run_test
    int longs_done;
    int pick;
    int idx;
    longs_done = 0;

    // Directed: each command, each reject cause but count and length, edge bytes
    pending_chars.push_back('{ch: "a", first: 1'b0});
    send_text("lf()");
    send_text("lv(\"a\",b)");
    send_text("get(x)");
    send_text("read(\"r\")");
    send_text("set(\"k\",v)");
    send_text("write(1,2)");
    send_text("fn(a,b,c,d,e)");
    send_text("(x)");
    send_text("f(a,,b)");
    send_text("get(ab");
    send_text("~!(~)zz");
    append_str("ge");
    line_buf.push_back(8'h00);
    emit_line();
    append_str("x(");
    line_buf.push_back(8'hFF);
    emit_line();

    // Random: mostly well-formed commands, some broken ones, a few full-length lines;
    // leave room for the full-length lines still to come
    while (queued_chars + (LONG_FORMS - longs_done) * MAX_LINE < RANDOM_TARGET) begin
      pick = $urandom_range(99);
      if (longs_done < LONG_FORMS && pick < 3) begin
        build_long(longs_done);
        longs_done++;
      end else begin
        build_command();
        if (pick >= 75) begin
          case ($urandom_range(4))
            0: line_buf[$urandom_range(line_buf.size() - 1)] = pick_illegal();
            1: while (line_buf[0] != CH_OPEN) void'(line_buf.pop_front());
            2: begin
              idx = 0;
              while (line_buf[idx] != CH_OPEN) idx++;
              line_buf.insert(idx + 1, CH_COMMA);
            end
            3: line_buf = line_buf[0:$urandom_range(line_buf.size() - 2)];
            default: repeat ($urandom_range(3, 1)) line_buf.push_back(pick_legal(1'b0));
          endcase
        end
      end
      emit_line();
    end
    while (longs_done < LONG_FORMS) begin
      build_long(longs_done);
      longs_done++;
      emit_line();
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_chars.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("sent %0d characters; checked %0d parameters, %0d accepted, %0d rejected",
             chars_sent, params_seen, accepts_seen, rejects_seen);
    $display("rejects by cause (illegal..too long): %0d %0d %0d %0d %0d %0d %0d",
             reason_hits[1], reason_hits[2], reason_hits[3], reason_hits[4],
             reason_hits[5], reason_hits[6], reason_hits[7]);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches in total", mismatch_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/sclt_pkg.sv
sv/sclt_front.sv
sv/sclt_fifo.sv
sv/sclt_back.sv
sv/shell_command_line_tokenizer.sv
verif/tb.sv
